FILE: hdl/convex_polygon_plane_clipper_assert.svh
// assertion macros shared by the checker
`ifndef CONVEX_POLYGON_PLANE_CLIPPER_ASSERT_SVH
`define CONVEX_POLYGON_PLANE_CLIPPER_ASSERT_SVH

// implication checked every clock outside reset
`define CPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");

// implication checked on the next clock
`define CPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

FILE: hdl/cpc_pkg.sv
//------------------------------------------------------------------------------
// cpc_pkg
// shared types and constants of the polygon plane clipper
//------------------------------------------------------------------------------
`default_nettype none
package cpc_pkg;
  localparam int CoordW = 32;
  localparam int FracBits = 16;
  localparam int DistW = 64;
  localparam int QBits = 16;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegNx = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNy = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNz = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPx = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPy = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPz = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBand = 3'd6;

  typedef struct packed {
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
    logic poly_last;
  } vin_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic has_vertex;
    logic is_cut;
    logic run_last;
    logic poly_end;
  } vout_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIST, OP_MUL, OP_SUM, OP_CLASS, OP_DIV_START, OP_DIV_STEP,
    OP_CUT_MUL, OP_CUT_ADD, OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t op;
    logic [1:0] axis;      // coordinate lane for multiply steps
    logic closing;         // edge back to first vertex
  } cmd_t;

  typedef struct packed {
    logic have_first;
    logic last;
    logic emit_a;          // start vertex not behind
    logic do_cut;          // ends strictly on opposite sides
    logic close_emits;     // closing edge leaves at least one beat
  } sts_t;
endpackage
`default_nettype wire

FILE: hdl/cpc_if.sv
//------------------------------------------------------------------------------
// cpc_if
// valid/ready channel carrying one payload
//------------------------------------------------------------------------------
`default_nettype none
interface cpc_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/convex_polygon_plane_clipper.sv
// throughput: one vertex at a time; up to two serial 16-step cut divides per vertex
// results leave through a one-deep output register, so a stalled sink holds the block
// synchronous active-high reset clears control and loads the register reset values
//------------------------------------------------------------------------------
// convex_polygon_plane_clipper
// single plane clipper for a streamed convex polygon
//------------------------------------------------------------------------------
`default_nettype none
module convex_polygon_plane_clipper (
  input  wire logic clk,
  input  wire logic rst,
  cpc_if.sink   vin,
  cpc_if.source vout,
  input  wire logic cfg_we,
  input  wire logic [cpc_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [31:0] cfg_data
);
  import cpc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  vout_t vtx, res;
  logic signed [CoordW-1:0] cx, cy, cz;
  logic emit_vtx, emit_cut, emit_bare, emit_final, emit_runlast;
  logic out_free;
  logic ovalid;
  vout_t odata;

  cpc_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .vin(vin.data), .cmd(cmd), .sts(sts), .vtx(vtx),
    .cut_x(cx), .cut_y(cy), .cut_z(cz)
  );

  cpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(vin.valid), .in_ready(vin.ready),
    .sts(sts), .cmd(cmd), .emit_vtx(emit_vtx), .emit_cut(emit_cut),
    .emit_bare(emit_bare), .emit_final(emit_final), .emit_runlast(emit_runlast),
    .out_free(out_free)
  );

  assign out_free = !ovalid || vout.ready;

  always_comb begin
    res = vtx;
    if (emit_cut) begin
      res.out_x = cx; res.out_y = cy; res.out_z = cz; res.is_cut = 1'b1;
    end else if (emit_bare) begin
      res = '0;
    end
    res.run_last = emit_runlast;
    res.poly_end = emit_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit_vtx || emit_cut || emit_bare) begin
      ovalid <= 1'b1;
    end else if (vout.ready) begin
      ovalid <= 1'b0;
    end
    if (emit_vtx || emit_cut || emit_bare) odata <= res;
  end

  assign vout.valid = ovalid;
  assign vout.data = odata;
endmodule
`default_nettype wire

FILE: hdl/cpc_datapath.sv
//------------------------------------------------------------------------------
// cpc_datapath
// registers, distance mac, serial divider and cut interpolation
//------------------------------------------------------------------------------
`default_nettype none
module cpc_datapath (
  input  wire logic clk,
  input  wire logic cfg_we,
  input  wire logic [cpc_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic rst,
  input  cpc_pkg::vin_t vin,
  input  cpc_pkg::cmd_t cmd,
  output cpc_pkg::sts_t sts,
  output cpc_pkg::vout_t vtx,    // start vertex of the current edge
  output logic signed [cpc_pkg::CoordW-1:0] cut_x,
  output logic signed [cpc_pkg::CoordW-1:0] cut_y,
  output logic signed [cpc_pkg::CoordW-1:0] cut_z
);
  import cpc_pkg::*;

  logic signed [CoordW-1:0] nrm [3];
  logic signed [CoordW-1:0] pnt [3];
  logic [15:0] band;
  logic signed [CoordW-1:0] cur [3];
  logic signed [CoordW-1:0] fst [3];
  logic signed [CoordW-1:0] prv [3];
  logic signed [DistW-1:0] d_cur, d_fst, d_prv;
  logic have_first, last;
  logic signed [65:0] prod;
  logic signed [67:0] acc;
  logic emit_a, do_cut, close_emits;
  logic [64:0] dv_rem;
  logic [64:0] dv_sum;
  logic [QBits-1:0] q;
  logic signed [CoordW-1:0] ea [3];
  logic signed [CoordW-1:0] eb [3];
  logic signed [DistW-1:0] da, db;
  logic signed [CoordW-1:0] cut [3];
  logic signed [50:0] cprod_a, cprod_b;
  logic signed [DistW-1:0] thr;
  logic [DistW-1:0] ma, mb;
  logic [64:0] r2;
  logic signed [32:0] diff;
  logic signed [DistW-1:0] d_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= '0; nrm[1] <= '0; nrm[2] <= 32'sd65536;
      pnt[0] <= '0; pnt[1] <= '0; pnt[2] <= '0;
      band <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegNx: nrm[0] <= cfg_data;
        RegNy: nrm[1] <= cfg_data;
        RegNz: nrm[2] <= cfg_data;
        RegPx: pnt[0] <= cfg_data;
        RegPy: pnt[1] <= cfg_data;
        RegPz: pnt[2] <= cfg_data;
        RegBand: band <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // edge ends: previous to current, or current to first when closing
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea[i] = cmd.closing ? cur[i] : prv[i];
      eb[i] = cmd.closing ? fst[i] : cur[i];
    end
    da = cmd.closing ? d_cur : d_prv;
    db = cmd.closing ? d_fst : d_cur;
  end

  // saturate the exact sum to 64 bits
  always_comb begin
    if (acc > 68'sh0_7FFF_FFFF_FFFF_FFFF) d_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (acc < -68'sh0_8000_0000_0000_0000) d_sat = 64'sh8000_0000_0000_0000;
    else d_sat = acc[63:0];
  end

  assign thr = DistW'({band, 16'h0000});
  assign ma = da[DistW-1] ? DistW'(-da) : da;
  assign mb = db[DistW-1] ? DistW'(-db) : db;
  assign diff = 33'(cur[cmd.axis]) - 33'(pnt[cmd.axis]);
  assign r2 = {dv_rem[63:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
    end else if (cmd.op == OP_COMMIT) begin
      have_first <= !last;
    end
    case (cmd.op)
      OP_LOAD: begin
        cur[0] <= vin.in_x; cur[1] <= vin.in_y; cur[2] <= vin.in_z;
        last <= vin.poly_last;
        acc <= '0;
      end
      OP_MUL: prod <= 66'(nrm[cmd.axis]) * 66'(diff);
      OP_SUM: acc <= acc + 68'(prod);
      OP_DIST: begin
        d_cur <= d_sat;
        if (!have_first) begin
          fst <= cur;
          d_fst <= d_sat;
        end
      end
      OP_CLASS: begin
        emit_a <= !(da < -thr);
        do_cut <= ((da > thr) && (db < -thr)) || ((da < -thr) && (db > thr));
        // closing edge gives the current vertex or a cut toward a front first vertex
        close_emits <= !(d_cur < -thr) || (d_fst > thr);
      end
      OP_DIV_START: begin
        dv_rem <= {1'b0, ma};
        dv_sum <= {1'b0, ma} + {1'b0, mb};
        q <= '0;
      end
      OP_DIV_STEP: begin
        if (r2 >= dv_sum) begin
          dv_rem <= r2 - dv_sum;
          q <= {q[QBits-2:0], 1'b1};
        end else begin
          dv_rem <= r2;
          q <= {q[QBits-2:0], 1'b0};
        end
      end
      OP_CUT_MUL: begin
        cprod_a <= 51'(ea[cmd.axis]) * 51'(18'sd65536 - 18'($signed({1'b0, q})));
        cprod_b <= 51'(eb[cmd.axis]) * 51'($signed({1'b0, q}));
      end
      OP_CUT_ADD: begin
        cut[cmd.axis] <= 32'((cprod_a + cprod_b) >>> FracBits);
      end
      OP_COMMIT: begin
        if (!last) begin
          prv <= cur;
          d_prv <= d_cur;
        end
      end
      default: ;
    endcase
  end

  assign sts = '{have_first: have_first, last: last, emit_a: emit_a, do_cut: do_cut,
                 close_emits: close_emits};
  assign vtx = '{out_x: ea[0], out_y: ea[1], out_z: ea[2], has_vertex: 1'b1,
                 is_cut: 1'b0, run_last: 1'b0, poly_end: 1'b0};
  assign cut_x = cut[0];
  assign cut_y = cut[1];
  assign cut_z = cut[2];
endmodule
`default_nettype wire

FILE: hdl/cpc_ctrl.sv
//------------------------------------------------------------------------------
// cpc_ctrl
// sequencer for distance, edge classing, divide and result beats
//------------------------------------------------------------------------------
`default_nettype none
module cpc_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  cpc_pkg::sts_t sts,
  output cpc_pkg::cmd_t cmd,
  output logic emit_vtx,
  output logic emit_cut,
  output logic emit_bare,
  output logic emit_final,
  output logic emit_runlast,
  input  wire logic out_free
);
  import cpc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001, S_MUL = 11'b00000000010, S_SUM = 11'b00000000100,
    S_DIST = 11'b00000001000, S_CLASS = 11'b00000010000, S_EMIT_A = 11'b00000100000,
    S_DIV = 11'b00001000000, S_CMUL = 11'b00010000000, S_CADD = 11'b00100000000,
    S_EMIT_C = 11'b01000000000, S_DONE = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] axis, axis_next;
  logic [4:0] step, step_next;
  logic closing, closing_next;
  logic emitted, emitted_next;
  logic has_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; axis <= '0; step <= '0; closing <= 1'b0; emitted <= 1'b0;
    end else begin
      state <= state_next; axis <= axis_next; step <= step_next;
      closing <= closing_next; emitted <= emitted_next;
    end
  end

  always_comb begin
    state_next = state; axis_next = axis; step_next = step;
    closing_next = closing; emitted_next = emitted;
    cmd = '{op: OP_NONE, axis: axis, closing: closing};
    in_ready = 1'b0;
    emit_vtx = 1'b0; emit_cut = 1'b0; emit_bare = 1'b0;
    emit_final = 1'b0; emit_runlast = 1'b0;
    has_edge = sts.have_first;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          axis_next = '0; closing_next = 1'b0; emitted_next = 1'b0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = OP_MUL; state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op = OP_SUM;
        if (axis == 2'd2) begin
          axis_next = '0; state_next = S_DIST;
        end else begin
          axis_next = axis + 2'd1; state_next = S_MUL;
        end
      end
      S_DIST: begin
        cmd.op = OP_DIST;
        // without a previous vertex only the closing edge can follow
        if (!has_edge && sts.last) closing_next = 1'b1;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        cmd.op = OP_CLASS;
        if (!has_edge && !closing) state_next = S_DONE;
        else state_next = S_EMIT_A;
        if (!sts.have_first && !sts.last) state_next = S_DONE;
      end
      S_EMIT_A: begin
        if (!sts.emit_a) begin
          state_next = sts.do_cut ? S_DIV : S_DONE;
          cmd.op = sts.do_cut ? OP_DIV_START : OP_NONE;
          step_next = '0;
        end else if (out_free) begin
          emit_vtx = 1'b1; emitted_next = 1'b1;
          emit_runlast = !sts.do_cut && (closing || !sts.last || !sts.close_emits);
          emit_final = !sts.do_cut && (closing || (sts.last && !sts.close_emits));
          cmd.op = sts.do_cut ? OP_DIV_START : OP_NONE;
          step_next = '0;
          state_next = sts.do_cut ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        step_next = step + 5'd1;
        if (step == 5'(QBits - 1)) begin
          axis_next = '0; state_next = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd.op = OP_CUT_MUL; state_next = S_CADD;
      end
      S_CADD: begin
        cmd.op = OP_CUT_ADD;
        if (axis == 2'd2) begin
          axis_next = '0; state_next = S_EMIT_C;
        end else begin
          axis_next = axis + 2'd1; state_next = S_CMUL;
        end
      end
      S_EMIT_C: begin
        if (out_free) begin
          emit_cut = 1'b1; emitted_next = 1'b1;
          emit_runlast = closing || !sts.last || !sts.close_emits;
          emit_final = closing || (sts.last && !sts.close_emits);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!closing && sts.last) begin
          closing_next = 1'b1; state_next = S_CLASS;
        end else if (closing && !emitted) begin
          if (out_free) begin
            emit_bare = 1'b1; emit_runlast = 1'b1; emit_final = 1'b1;
            cmd.op = OP_COMMIT; state_next = S_IDLE;
          end
        end else begin
          cmd.op = OP_COMMIT; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/cpc_checker.sv
//------------------------------------------------------------------------------
// cpc_checker
// port-level checks of the clipper, bound to the top level
//------------------------------------------------------------------------------
`default_nettype none
`include "convex_polygon_plane_clipper_assert.svh"
module cpc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic has_vertex,
  input wire logic is_cut,
  input wire logic run_last,
  input wire logic poly_end
);
  `CPC_ASSERT_IMP(a_end_is_run_last, out_valid && poly_end, run_last)
  `CPC_ASSERT_IMP(a_bare_is_end, out_valid && !has_vertex, poly_end && !is_cut)
  `CPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CPC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
endmodule

bind convex_polygon_plane_clipper cpc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(vin.valid), .in_ready(vin.ready),
  .out_valid(vout.valid), .out_ready(vout.ready),
  .has_vertex(vout.data.has_vertex), .is_cut(vout.data.is_cut),
  .run_last(vout.data.run_last), .poly_end(vout.data.poly_end)
);
`default_nettype wire

FILE: bench/cpc_clip_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cpc_clip_checker
// watches the vertex and result channels and the register port, predicts
// the clipped polygon of every vertex beat and compares each result beat
//------------------------------------------------------------------------------
`default_nettype none
module cpc_clip_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  cpc_pkg::vin_t in_beat,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  cpc_pkg::vout_t out_beat,
  input  wire logic cfg_we,
  input  wire logic [cpc_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [31:0] cfg_data,
  output int fail_count,
  output int pending
);
  import cpc_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vtx_t;

  localparam logic signed [127:0] DistMax = {64'd0, 64'h7fff_ffff_ffff_ffff};
  localparam logic signed [127:0] DistMin = ~DistMax;

  logic signed [CoordW-1:0] nrm_x, nrm_y, nrm_z, pnt_x, pnt_y, pnt_z;
  logic [15:0] band;
  vtx_t first_v, prev_v;
  logic signed [DistW-1:0] first_d, prev_d;
  logic have_first;
  vout_t clipped_q[$];
  int beat_count;

  // each axis product wraps to 64 bits before the exact sum, then saturate
  function automatic logic signed [DistW-1:0] axis_term(input logic signed [CoordW-1:0] n,
      input logic signed [CoordW-1:0] v, input logic signed [CoordW-1:0] p);
    logic signed [127:0] nw, vw, pw, prod;
    nw = n;
    vw = v;
    pw = p;
    prod = nw * (vw - pw);
    return prod[63:0];
  endfunction

  function automatic logic signed [DistW-1:0] plane_distance(input vtx_t v);
    logic signed [127:0] s, tx, ty, tz;
    tx = axis_term(nrm_x, v.x, pnt_x);
    ty = axis_term(nrm_y, v.y, pnt_y);
    tz = axis_term(nrm_z, v.z, pnt_z);
    s = tx + ty + tz;
    if (s > DistMax) return DistMax[63:0];
    if (s < DistMin) return DistMin[63:0];
    return s[63:0];
  endfunction

  function automatic int side_of(input logic signed [DistW-1:0] d);
    logic signed [DistW-1:0] thr;
    thr = {32'd0, band, 16'd0};
    if (d > thr) return 1;
    if (d < -thr) return -1;
    return 0;
  endfunction

  function automatic logic signed [CoordW-1:0] cut_coord(input logic signed [CoordW-1:0] a,
      input logic signed [CoordW-1:0] b, input logic signed [127:0] lam);
    logic signed [127:0] aw, bw, acc;
    aw = a;
    bw = b;
    acc = aw * (128'sd65536 - lam) + bw * lam;
    acc = acc >>> 16;
    return acc[31:0];
  endfunction

  function automatic vout_t make_vertex(input vtx_t v, input logic cut);
    vout_t r;
    r = '0;
    r.out_x = v.x;
    r.out_y = v.y;
    r.out_z = v.z;
    r.has_vertex = 1'b1;
    r.is_cut = cut;
    return r;
  endfunction

  task automatic clip_edge(input vtx_t a, input logic signed [DistW-1:0] da,
      input vtx_t b, input logic signed [DistW-1:0] db, inout int n);
    int sa, sb;
    logic signed [127:0] ma, mb, wa, wb, lam;
    vtx_t c;
    sa = side_of(da);
    sb = side_of(db);
    if (sa != -1) begin
      clipped_q.push_back(make_vertex(a, 1'b0));
      n++;
    end
    if (sa != 0 && sb != 0 && sa != sb) begin
      wa = da;
      wb = db;
      ma = (wa < 0) ? -wa : wa;
      mb = (wb < 0) ? -wb : wb;
      lam = (ma <<< 16) / (ma + mb);
      c.x = cut_coord(a.x, b.x, lam);
      c.y = cut_coord(a.y, b.y, lam);
      c.z = cut_coord(a.z, b.z, lam);
      clipped_q.push_back(make_vertex(c, 1'b1));
      n++;
    end
  endtask

  task automatic predict_vertex(input vin_t beat);
    vtx_t v;
    logic signed [DistW-1:0] d;
    int n;
    n = 0;
    v.x = beat.in_x;
    v.y = beat.in_y;
    v.z = beat.in_z;
    d = plane_distance(v);
    if (!have_first) begin
      first_v = v;
      first_d = d;
    end else begin
      clip_edge(prev_v, prev_d, v, d, n);
    end
    if (beat.poly_last) begin
      clip_edge(v, d, first_v, first_d, n);
      if (n == 0) begin
        clipped_q.push_back('0);
        n++;
      end
      clipped_q[clipped_q.size()-1].poly_end = 1'b1;
      have_first = 1'b0;
    end else begin
      prev_v = v;
      prev_d = d;
      have_first = 1'b1;
    end
    if (n > 0) clipped_q[clipped_q.size()-1].run_last = 1'b1;
  endtask

  task automatic check_result(input vout_t got);
    vout_t want;
    if (clipped_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%t unexpected result beat %h", $realtime, got);
      return;
    end
    want = clipped_q.pop_front();
    if (got.out_x !== want.out_x || got.out_y !== want.out_y || got.out_z !== want.out_z ||
        got.has_vertex !== want.has_vertex || got.is_cut !== want.is_cut ||
        got.run_last !== want.run_last || got.poly_end !== want.poly_end) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%t result %0d: exp x=%h y=%h z=%h hv=%b cut=%b rl=%b pe=%b, got x=%h y=%h z=%h hv=%b cut=%b rl=%b pe=%b",
                 $realtime, beat_count, want.out_x, want.out_y, want.out_z, want.has_vertex,
                 want.is_cut, want.run_last, want.poly_end, got.out_x, got.out_y, got.out_z,
                 got.has_vertex, got.is_cut, got.run_last, got.poly_end);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    beat_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      nrm_x = '0;
      nrm_y = '0;
      nrm_z = 32'sd65536;
      pnt_x = '0;
      pnt_y = '0;
      pnt_z = '0;
      band = 16'd7;
      first_v = '0;
      prev_v = '0;
      first_d = '0;
      prev_d = '0;
      have_first = 1'b0;
      clipped_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_beat);
        beat_count++;
      end
      if (cfg_we) begin
        case (cfg_idx)
          RegNx: nrm_x = cfg_data;
          RegNy: nrm_y = cfg_data;
          RegNz: nrm_z = cfg_data;
          RegPx: pnt_x = cfg_data;
          RegPy: pnt_y = cfg_data;
          RegPz: pnt_z = cfg_data;
          RegBand: band = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_vertex(in_beat);
    end
    pending = clipped_q.size();
  end
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_top
// streams directed and random polygons through the plane clipper under
// several plane settings with random stalls; the checker scores results
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import cpc_pkg::*;

  localparam int OneQ = 65536;
  localparam int IdleLimit = 3000;
  localparam int ItemGoal = 380;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [31:0] cfg_data;
  int fail_count;
  int pending;
  int items_sent;
  int gap_odds;
  int stall_odds;
  bit quiet;
  int idle_cycles;
  logic [31:0] shadow_px, shadow_py, shadow_pz;

  cpc_if #(.payload_t(vin_t)) vin_ch ();
  cpc_if #(.payload_t(vout_t)) vout_ch ();

  convex_polygon_plane_clipper DUT (
    .clk(clk),
    .rst(rst),
    .vin(vin_ch.sink),
    .vout(vout_ch.source),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  cpc_clip_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(vin_ch.valid),
    .in_ready(vin_ch.ready),
    .in_beat(vin_ch.data),
    .out_valid(vout_ch.valid),
    .out_ready(vout_ch.ready),
    .out_beat(vout_ch.data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // no progress on either channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (vin_ch.valid && vin_ch.ready) || (vout_ch.valid && vout_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL convex_polygon_plane_clipper");
        $finish;
      end
    end
  end

  // result sink with random stall bursts
  initial begin
    vout_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (rst || quiet || $urandom_range(0, 99) >= stall_odds) begin
        vout_ch.ready <= 1'b1;
      end else begin
        vout_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        vout_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z, input logic last);
    vin_t beat;
    beat.in_x = x;
    beat.in_y = y;
    beat.in_z = z;
    beat.poly_last = last;
    vin_ch.valid <= 1'b1;
    vin_ch.data <= beat;
    @(posedge clk);
    while (!vin_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_odds) begin
      vin_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // hold off until every result is out and the block has settled
  task automatic drain();
    vin_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == RegPx) shadow_px = val;
    if (idx == RegPy) shadow_py = val;
    if (idx == RegPz) shadow_pz = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_normal();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'd0;
      default: return $urandom_range(0, 4 * OneQ) - 2 * OneQ;
    endcase
  endfunction

  function automatic logic [31:0] pick_coord(input int mode, input logic [31:0] on_plane);
    case (mode)
      0: return $urandom;
      1: return ($urandom_range(0, 3) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return on_plane;
      default: return $urandom_range(0, 16 * OneQ) - 8 * OneQ;
    endcase
  endfunction

  task automatic random_plane();
    int sel;
    drain();
    write_reg(RegNx, pick_normal());
    write_reg(RegNy, pick_normal());
    write_reg(RegNz, pick_normal());
    sel = $urandom_range(0, 3);
    write_reg(RegPx, (sel == 0) ? $urandom : $urandom_range(0, 4 * OneQ) - 2 * OneQ);
    write_reg(RegPy, (sel == 0) ? $urandom : $urandom_range(0, 4 * OneQ) - 2 * OneQ);
    write_reg(RegPz, (sel == 0) ? $urandom : $urandom_range(0, 4 * OneQ) - 2 * OneQ);
    case ($urandom_range(0, 3))
      0: write_reg(RegBand, 32'd0);
      1: write_reg(RegBand, 32'h0000_ffff);
      default: write_reg(RegBand, $urandom);
    endcase
    // unused index, must be ignored
    if ($urandom_range(0, 3) == 0) write_reg(3'd7, $urandom);
    gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
  endtask

  task automatic random_polygon();
    int nv, mode;
    nv = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
    for (int i = 0; i < nv; i++) begin
      mode = $urandom_range(0, 9);
      if (mode >= 4) mode = 3;
      send_vertex(pick_coord(mode, shadow_px), pick_coord(mode, shadow_py),
                  pick_coord(mode, shadow_pz), i == nv - 1);
    end
  endtask

  initial begin
    rst = 1'b1;
    vin_ch.valid = 1'b0;
    vin_ch.data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    items_sent = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    gap_odds = 20;
    stall_odds = 20;
    shadow_px = '0;
    shadow_py = '0;
    shadow_pz = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset plane z=0, front is +z
    send_vertex(0, 0, OneQ, 1'b0);
    send_vertex(OneQ, 0, -OneQ, 1'b0);
    send_vertex(0, OneQ, OneQ, 1'b1);
    // wholly behind: bare end marker
    send_vertex(0, 0, -OneQ, 1'b0);
    send_vertex(OneQ, 0, -OneQ, 1'b0);
    send_vertex(0, OneQ, -2 * OneQ, 1'b1);
    // single vertex, front then behind
    send_vertex(5 * OneQ, -3 * OneQ, 2 * OneQ, 1'b1);
    send_vertex(5 * OneQ, -3 * OneQ, -2 * OneQ, 1'b1);
    // inside the tolerance band on both signs
    send_vertex(OneQ, OneQ, 3, 1'b0);
    send_vertex(-OneQ, OneQ, -5, 1'b0);
    send_vertex(0, -OneQ, -OneQ, 1'b1);
    // coordinate extremes
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);

    // extreme plane: distances saturate, band at full width
    drain();
    write_reg(RegNx, 32'h7fff_ffff);
    write_reg(RegNy, 32'h8000_0000);
    write_reg(RegNz, 32'h8000_0000);
    write_reg(RegPx, 32'h8000_0000);
    write_reg(RegPy, 32'h7fff_ffff);
    write_reg(RegPz, 32'h7fff_ffff);
    write_reg(RegBand, 32'h0000_ffff);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);

    // zero band, vertex on the plane point
    drain();
    write_reg(RegNx, OneQ);
    write_reg(RegNy, -OneQ);
    write_reg(RegNz, 0);
    write_reg(RegPx, OneQ);
    write_reg(RegPy, 0);
    write_reg(RegPz, 0);
    write_reg(RegBand, 32'd0);
    write_reg(3'd7, 32'hffff_ffff);
    send_vertex(OneQ, 0, 7, 1'b0);
    send_vertex(3 * OneQ, 0, 0, 1'b0);
    send_vertex(0, 2 * OneQ, OneQ, 1'b0);
    send_vertex(OneQ, 1, -1, 1'b1);

    while (items_sent < ItemGoal) begin
      if ($urandom_range(0, 7) == 0) random_plane();
      if (items_sent >= ItemGoal - 50) quiet = 1'b1;
      random_polygon();
    end
    vin_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS convex_polygon_plane_clipper");
    end else begin
      $display("FAIL convex_polygon_plane_clipper");
    end
    $finish;
  end
endmodule
`default_nettype wire
